// ===== hdl/hessdet_pkg.sv =====
// Shared constants and pipeline control type for the 3x3 Hessian determinant filter.
package hessdet_pkg;

  // Parameter defaults
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned PixelBitsDef = 16;

  // Fixed field widths
  localparam int unsigned PixelW  = 16;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned RowW    = 16;
  localparam int unsigned ColOutW = 12;
  localparam int unsigned RespW   = 40;

  // Row width limits and reset value
  localparam int unsigned MinWidth   = 3;
  localparam int unsigned WidthReset = 640;

  // Row counter saturation value and first row/column that produces a result
  localparam logic [RowW-1:0] RowMax   = '1;
  localparam int unsigned     FirstOut = 2;

  // Stage load strobes handed from the top level to the datapath
  typedef struct packed {
    logic adv1;  // stage 1 item leaves (window shifts, upper line written)
    logic ld2;   // differences register loads
    logic ld3;   // product register loads
    logic ldo;   // result register loads
  } pipe_ctl_t;

endpackage

// ===== hdl/hessdet_linebuf.sv =====
// Two line buffer memories with a bypass for a pending upper-line write.
module hessdet_linebuf #(
  parameter int unsigned MAX_WIDTH  = hessdet_pkg::MaxWidthDef,
  parameter int unsigned PIXEL_BITS = hessdet_pkg::PixelBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic [PIXEL_BITS-1:0]        pix_i,
  input  logic                         up_we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] up_waddr_i,
  output logic [PIXEL_BITS-1:0]        top_o,
  output logic [PIXEL_BITS-1:0]        mid_o
);
  import hessdet_pkg::*;

  logic [PIXEL_BITS-1:0] mem_up  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_mid [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] up_rd_q;
  logic [PIXEL_BITS-1:0] mid_rd_q;
  logic [PIXEL_BITS-1:0] byp_data_q;
  logic                  byp_q;

  // Middle line: read old value, write new pixel, same address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_rd_q          <= mem_mid[rd_addr_i];
      mem_mid[rd_addr_i] <= pix_i;
    end
  end

  // Upper line: read at accept, written one stage later with the middle value
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q <= mem_up[rd_addr_i];
    end
    if (up_we_i) begin
      mem_up[up_waddr_i] <= mid_o;
    end
  end

  // Same-address write and read in one cycle: forward the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= up_we_i && (up_waddr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= mid_o;
    end
  end

  assign mid_o = mid_rd_q;
  assign top_o = byp_q ? byp_data_q : up_rd_q;

endmodule

// ===== hdl/hessdet_window.sv =====
// 3x3 window registers and second differences, registered.
module hessdet_window #(
  parameter int unsigned PIXEL_BITS = hessdet_pkg::PixelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hessdet_pkg::pipe_ctl_t        ctl_i,
  input  logic [PIXEL_BITS-1:0]         top_i,
  input  logic [PIXEL_BITS-1:0]         mid_i,
  input  logic [PIXEL_BITS-1:0]         pix_i,
  output logic signed [PIXEL_BITS+1:0]  lxx_o,
  output logic signed [PIXEL_BITS+1:0]  lyy_o,
  output logic signed [PIXEL_BITS+1:0]  dxy_o
);
  import hessdet_pkg::*;

  localparam int unsigned DW = PIXEL_BITS + 2;

  // Two older columns of the window: top, middle, bottom rows
  logic [PIXEL_BITS-1:0] w_q [6];

  logic signed [DW-1:0] v11, v12, v13, v21, v22, v23, v31, v32, v33;
  logic signed [DW-1:0] lxx_d, lyy_d, dxy_d;
  logic signed [DW-1:0] lxx_q, lyy_q, dxy_q;

  // Zero-extend into the signed difference width
  assign v11 = $signed({2'b00, w_q[0]});
  assign v12 = $signed({2'b00, w_q[1]});
  assign v13 = $signed({2'b00, top_i});
  assign v21 = $signed({2'b00, w_q[2]});
  assign v22 = $signed({2'b00, w_q[3]});
  assign v23 = $signed({2'b00, mid_i});
  assign v31 = $signed({2'b00, w_q[4]});
  assign v32 = $signed({2'b00, w_q[5]});
  assign v33 = $signed({2'b00, pix_i});

  // Second differences and mixed difference (4 * Lxy)
  always_comb begin
    lxx_d = v21 - (v22 <<< 1) + v23;
    lyy_d = v12 - (v22 <<< 1) + v32;
    dxy_d = v13 - v11 + v31 - v33;
  end

  // Window shift on every item leaving stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        w_q[i] <= '0;
      end
    end else if (ctl_i.adv1) begin
      w_q[0] <= w_q[1];
      w_q[1] <= top_i;
      w_q[2] <= w_q[3];
      w_q[3] <= mid_i;
      w_q[4] <= w_q[5];
      w_q[5] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      lxx_q <= lxx_d;
      lyy_q <= lyy_d;
      dxy_q <= dxy_d;
    end
  end

  assign lxx_o = lxx_q;
  assign lyy_o = lyy_q;
  assign dxy_o = dxy_q;

endmodule

// ===== hdl/hessdet_resp.sv =====
// Product stage and result register: 16*Lxx*Lyy - D*D.
module hessdet_resp #(
  parameter int unsigned PIXEL_BITS = hessdet_pkg::PixelBitsDef
) (
  input  logic                                clk_i,
  input  hessdet_pkg::pipe_ctl_t              ctl_i,
  input  logic signed [PIXEL_BITS+1:0]        lxx_i,
  input  logic signed [PIXEL_BITS+1:0]        lyy_i,
  input  logic signed [PIXEL_BITS+1:0]        dxy_i,
  output logic signed [hessdet_pkg::RespW-1:0] resp_o
);
  import hessdet_pkg::*;

  localparam int unsigned PW = 2 * (PIXEL_BITS + 2);

  logic signed [PW-1:0]    prod_q;
  logic signed [PW-1:0]    sq_q;
  logic signed [RespW-1:0] prod_ext;
  logic signed [RespW-1:0] sq_ext;
  logic signed [RespW-1:0] resp_q;

  // Two multipliers side by side
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      prod_q <= lxx_i * lyy_i;
      sq_q   <= dxy_i * dxy_i;
    end
  end

  assign prod_ext = RespW'(prod_q);
  assign sq_ext   = RespW'(sq_q);

  // Scale and subtract into the result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.ldo) begin
      resp_q <= (prod_ext <<< 4) - sq_ext;
    end
  end

  assign resp_o = resp_q;

endmodule

// ===== hdl/hessian_determinant_3x3.sv =====
// 3x3 Hessian determinant filter over a raster pixel stream: top level.
// One pixel item is taken every clock cycle while ready is high; a result for window
// centre (r-1, c-1) comes from the pixel at row r, column c (both at least 2) through
// the registered stages line buffer read, window and differences, two multipliers,
// scale and subtract. Border positions give no result. The line buffers are two memories
// of MAX_WIDTH entries, each read and written once per item; their contents are undefined
// after reset and need no clearing, since no result uses a row before it is written.
// Ready drops only while all four stages hold items and the result waits to be taken.
module hessian_determinant_3x3 #(
  parameter int unsigned MAX_WIDTH  = hessdet_pkg::MaxWidthDef,
  parameter int unsigned PIXEL_BITS = hessdet_pkg::PixelBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  image_width_we_i,
  input  logic [hessdet_pkg::CfgW-1:0]          image_width_i,
  // pixel items
  input  logic                                  pix_valid_i,
  output logic                                  pix_ready_o,
  input  logic [hessdet_pkg::PixelW-1:0]        pixel_i,
  input  logic                                  start_of_frame_i,
  // result items
  output logic                                  resp_valid_o,
  input  logic                                  resp_ready_i,
  output logic signed [hessdet_pkg::RespW-1:0]  response_x16_o,
  output logic [hessdet_pkg::RowW-1:0]          centre_row_o,
  output logic [hessdet_pkg::ColOutW-1:0]       centre_col_o
);
  import hessdet_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned MWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (MWW > CfgW) ? MWW : CfgW;
  localparam logic [CMPW-1:0] WidthMax = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] WidthMin = CMPW'(MinWidth);
  localparam logic [CMPW-1:0] WidthRst =
    (WidthReset > MAX_WIDTH) ? CMPW'(MAX_WIDTH) : CMPW'(WidthReset);

  // Configuration: clamped row width
  logic [CMPW-1:0] width_q, width_d, cfg_ext;

  // Raster counters
  logic [AW-1:0]   col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic            last_col;

  // Handshake and stage flags
  logic acc;
  logic rdy_o, rdy3, rdy2, rdy1;
  logic v1_q, v2_q, v3_q, ov_q;
  pipe_ctl_t ctl;

  // Stage payloads
  logic [PIXEL_BITS-1:0] pix_m, pix1_q;
  logic [AW-1:0]         col1_q;
  logic                  emit1_q;
  logic [RowW-1:0]       crow1_q, crow2_q, crow3_q, crow_q;
  logic [ColOutW-1:0]    ccol1_q, ccol2_q, ccol3_q, ccol_q;

  logic [PIXEL_BITS-1:0]        top, mid;
  logic signed [PIXEL_BITS+1:0] lxx, lyy, dxy;

  // Width register, clamped when written
  assign cfg_ext = CMPW'(image_width_i);

  always_comb begin
    if (cfg_ext < WidthMin) begin
      width_d = WidthMin;
    end else if (cfg_ext > WidthMax) begin
      width_d = WidthMax;
    end else begin
      width_d = cfg_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthRst;
    end else if (image_width_we_i) begin
      width_q <= width_d;
    end
  end

  // Ready chain: a stage takes an item when empty or when it empties this cycle
  assign rdy_o = !ov_q || resp_ready_i;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pix_ready_o = rdy1;
  assign acc = pix_valid_i && rdy1;

  assign ctl.adv1 = v1_q && rdy2;
  assign ctl.ld2  = v1_q && rdy2 && emit1_q;
  assign ctl.ld3  = v2_q && rdy3;
  assign ctl.ldo  = v3_q && rdy_o;

  // Position of the incoming pixel and next counter values
  assign col_cur  = start_of_frame_i ? '0 : col_q;
  assign row_cur  = start_of_frame_i ? '0 : row_q;
  assign last_col = (CMPW'(col_cur) + CMPW'(1)) >= width_q;
  assign pix_m    = pixel_i[PIXEL_BITS-1:0];

  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = (row_cur == RowMax) ? row_cur : row_cur + RowW'(1);
    end else begin
      col_d = col_cur + AW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      ov_q    <= 1'b0;
      emit1_q <= 1'b0;
    end else begin
      if (acc) begin
        v1_q    <= 1'b1;
        emit1_q <= (row_cur >= RowW'(FirstOut)) && (CMPW'(col_cur) >= CMPW'(FirstOut));
      end else if (ctl.adv1) begin
        v1_q <= 1'b0;
      end
      if (ctl.ld2) begin
        v2_q <= 1'b1;
      end else if (ctl.ld3) begin
        v2_q <= 1'b0;
      end
      if (ctl.ld3) begin
        v3_q <= 1'b1;
      end else if (ctl.ldo) begin
        v3_q <= 1'b0;
      end
      if (ctl.ldo) begin
        ov_q <= 1'b1;
      end else if (resp_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Stage payloads: pixel, column and window centre position
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix1_q  <= pix_m;
      col1_q  <= col_cur;
      crow1_q <= row_cur - RowW'(1);
      ccol1_q <= ColOutW'(col_cur - AW'(1));
    end
    if (ctl.ld2) begin
      crow2_q <= crow1_q;
      ccol2_q <= ccol1_q;
    end
    if (ctl.ld3) begin
      crow3_q <= crow2_q;
      ccol3_q <= ccol2_q;
    end
    if (ctl.ldo) begin
      crow_q <= crow3_q;
      ccol_q <= ccol3_q;
    end
  end

  hessdet_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_addr_i  (col_cur),
    .pix_i      (pix_m),
    .up_we_i    (ctl.adv1),
    .up_waddr_i (col1_q),
    .top_o      (top),
    .mid_o      (mid)
  );

  hessdet_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .top_i  (top),
    .mid_i  (mid),
    .pix_i  (pix1_q),
    .lxx_o  (lxx),
    .lyy_o  (lyy),
    .dxy_o  (dxy)
  );

  hessdet_resp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_resp (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .lxx_i  (lxx),
    .lyy_i  (lyy),
    .dxy_i  (dxy),
    .resp_o (response_x16_o)
  );

  assign resp_valid_o = ov_q;
  assign centre_row_o = crow_q;
  assign centre_col_o = ccol_q;

  // Checks

  // A result never carries the border row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o |-> (centre_row_o != '0))
    else $error("result with centre row zero");

  // Raster counters move only when an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> ($stable(col_q) && $stable(row_q)))
    else $error("raster counter moved without an item");

  // Taking an item while stage 1 is full means stage 1 empties in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && v1_q) |-> ctl.adv1)
    else $error("stage 1 overwritten");

  // Without start of frame the row count never falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !start_of_frame_i) |=> (row_q >= $past(row_q)))
    else $error("row counter went backwards");

endmodule
